### design/lpht_pkg.sv
package lpht_pkg;

   // Widths of the fields as they travel on the ports.
   localparam int KIND_W       = 2;
   localparam int KEY_PORT_W   = 16;
   localparam int VALUE_PORT_W = 16;
   localparam int STATUS_W     = 2;
   localparam int SLOT_PORT_W  = 4;
   localparam int FOUND_W      = 16;
   localparam int REQ_DATA_W   = KEY_PORT_W + VALUE_PORT_W;
   localparam int RSP_DATA_W   = 24;

   // Operation codes carried on req_tuser.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   // Result codes carried on rsp_tuser.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_ISSUE,
      S_PROBE
   } state_type;

endpackage

### design/lpht_home.sv
// Home slot of a key: the key modulo the table size. A power-of-two table takes
// the low bits into a register. Any other size multiplies the key by a rounded-up
// reciprocal of the table size to get the exact quotient, which is registered. The
// next cycle multiplies that quotient back and subtracts it from the key, and the
// difference is registered as the home slot.
module lpht_home
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_W       = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] home
);

   localparam int SW = $clog2(TABLE_SLOTS);
   localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic [SW+KEY_W-1:0] key_ext;
         logic [SW-1:0]       home_ff;
         logic                done_ff;

         assign key_ext = {{SW{1'b0}}, key};

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               home_ff <= key_ext[SW-1:0];
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_recip
         // With 2^(SW-1) < TABLE_SLOTS < 2^SW, the multiplier
         // floor(2^(KEY_W+SW) / TABLE_SLOTS) + 1 gives the exact quotient for
         // every KEY_W-bit key after a shift right by KEY_W + SW.
         localparam int QW = KEY_W + SW;
         localparam int PW = 2 * KEY_W + SW;
         localparam int SH = KEY_W + SW;
         localparam logic [63:0] RECIP = ((64'd1 << SH) / 64'(TABLE_SLOTS)) + 64'd1;
         localparam logic [PW-1:0] RECIP_P = PW'(RECIP);
         localparam logic [QW-1:0] SLOTS_Q = QW'(TABLE_SLOTS);

         logic [PW-1:0]    product;
         logic [KEY_W-1:0] quot_ff;
         logic [KEY_W-1:0] key_ff;
         logic [QW-1:0]    back;
         logic [QW-1:0]    diff;
         logic [SW-1:0]    rem_ff;
         logic             stage_ff;
         logic             done_ff;

         assign product = {{(PW - KEY_W){1'b0}}, key} * RECIP_P;
         assign back    = {{SW{1'b0}}, quot_ff} * SLOTS_Q;
         assign diff    = {{SW{1'b0}}, key_ff} - back;

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= 1'b0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= start;
               done_ff  <= stage_ff;
            end
            if (start) begin
               quot_ff <= product[SH +: KEY_W];
               key_ff  <= key;
            end
            if (stage_ff) begin
               rem_ff <= diff[SW-1:0];
            end
         end

         assign done = done_ff;
         assign home = rem_ff;
      end
   endgenerate

endmodule

### design/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing. Each request word carries an
// operation on req_tuser (insert, search or delete) and a key and value on
// req_tdata; each request returns exactly one response word with a status on
// rsp_tuser and the slot and found value on rsp_tdata. Insert takes the first
// empty slot from the key's home slot (key modulo TABLE_SLOTS) onward without a
// duplicate check; search and delete stop at an empty slot or a matching key,
// and delete simply empties the slot. Every probe gives up after one full pass
// and reports table full or key not found. The table lives in one synchronous
// RAM whose words hold a used flag, the key and the value. After reset the
// block sweeps the RAM to empty and holds req_tready low meanwhile. The home
// slot of a table whose size is not a power of two is found by a reciprocal
// multiplication. The probe loop reads one RAM word per cycle. A finished
// response waits in an output register, so a new request is taken while the
// previous response is pending; a probe that finishes while that register is
// still full waits there until the receiver takes the word.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 16,
   parameter int VALUE_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] lookup_key, [31:16] entry_value
   input  logic [KIND_W-1:0]     req_tuser,  // [1:0] kind
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] slot_index, [19:4] found_value, [23:20] zero
   output logic [STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   // Stored key and value widths never exceed what the ports can carry.
   localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
   localparam int VW    = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;
   localparam int SW    = $clog2(TABLE_SLOTS);
   localparam int MW    = 1 + KEY_W + VW;
   localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

   // The table RAM: {used, key, value} per slot.
   logic [MW-1:0] table_mem [TABLE_SLOTS];
   logic [MW-1:0] rd_q;
   logic [SW-1:0] rd_addr;
   logic [SW-1:0] wr_addr;
   logic [MW-1:0] wr_data;
   logic          wr_en;

   state_type state_ff, state_in;

   // Request held for the duration of the probe.
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VW-1:0]     value_ff, value_in;

   // Slot whose word is in rd_q during probing, and how many slots were passed.
   // During the clearing pass addr_ff walks the RAM instead.
   logic [SW-1:0] addr_ff, addr_in;
   logic [SW-1:0] count_ff, count_in;
   logic [SW-1:0] next_addr;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [SLOT_PORT_W-1:0] slot_ff, slot_in;
   logic [FOUND_W-1:0]     found_ff, found_in;

   // Home slot unit.
   logic          home_start;
   logic          home_done;
   logic [SW-1:0] home;

   // Probe decision.
   logic                   accept;
   logic                   out_free;
   logic                   stop;
   logic                   finish;
   logic                   rd_used;
   logic [KEY_W-1:0]       rd_key;
   logic [VW-1:0]          rd_value;
   logic [STATUS_W-1:0]    res_status;
   logic [VW-1:0]          res_value;
   logic                   res_write;
   logic [MW-1:0]          res_word;
   logic [SW+SLOT_PORT_W-1:0] slot_ext;
   logic [VW+FOUND_W-1:0]     value_ext;

   assign accept     = req_tvalid && req_tready;
   assign home_start = accept;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rd_used  = rd_q[MW-1];
   assign rd_key   = rd_q[KEY_W+VW-1:VW];
   assign rd_value = rd_q[VW-1:0];

   assign next_addr = (addr_ff == LAST_SLOT) ? '0 : addr_ff + SW'(1);

   lpht_home #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_W       (KEY_W)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (home_start),
      .key   (req_tdata[KEY_W-1:0]),
      .done  (home_done),
      .home  (home)
   );

   // Decide what the word in rd_q means for the request being probed. A stop
   // that lands while the output register is still full waits; the same slot is
   // then read again so that rd_q keeps its word.
   always_comb begin
      stop       = 1'b0;
      res_status = STATUS_MISSING;
      res_value  = '0;
      res_write  = 1'b0;
      res_word   = {1'b1, key_ff, value_ff};
      case (kind_ff) inside
         KIND_INSERT: begin
            if (!rd_used) begin
               stop       = 1'b1;
               res_status = STATUS_OK;
               res_write  = 1'b1;
            end else if (count_ff == LAST_SLOT) begin
               stop       = 1'b1;
               res_status = STATUS_FULL;
            end
         end
         KIND_SEARCH, KIND_DELETE: begin
            if (!rd_used) begin
               stop = 1'b1;
            end else if (rd_key == key_ff) begin
               stop       = 1'b1;
               res_status = STATUS_OK;
               res_value  = rd_value;
               res_write  = (kind_ff == KIND_DELETE);
               res_word   = {1'b0, rd_key, rd_value};
            end else if (count_ff == LAST_SLOT) begin
               stop = 1'b1;
            end
         end
         default: begin
            // An unknown operation touches nothing and reports a miss.
            stop = 1'b1;
         end
      endcase
   end

   assign finish    = (state_ff == S_PROBE) && stop && out_free;
   assign slot_ext  = {{SLOT_PORT_W{1'b0}}, addr_ff};
   assign value_ext = {{FOUND_W{1'b0}}, res_value};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (addr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_HOME;
            end
         end
         S_HOME: begin
            if (home_done) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Outputs, RAM controls and datapath registers.
   always_comb begin
      req_tready   = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = res_word;
      addr_in      = addr_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            addr_in = next_addr;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               kind_in  = req_tuser;
               key_in   = req_tdata[KEY_W-1:0];
               value_in = req_tdata[KEY_PORT_W +: VW];
            end
         end
         S_HOME: begin
            addr_in  = home;
            count_in = '0;
         end
         S_ISSUE: begin
            rd_addr = addr_ff;
         end
         S_PROBE: begin
            if (!stop) begin
               // Read ahead at the next slot; the word arrives next cycle.
               rd_addr  = next_addr;
               addr_in  = next_addr;
               count_in = count_ff + SW'(1);
            end else if (finish) begin
               wr_en        = res_write;
               rsp_valid_in = 1'b1;
               status_in    = res_status;
               slot_in      = (res_status == STATUS_OK) ? slot_ext[SLOT_PORT_W-1:0] : '0;
               found_in     = value_ext[FOUND_W-1:0];
            end
         end
         default: begin
            rd_addr = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      found_ff  <= found_in;
   end

   // Single-port-write, single-port-read RAM with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_q <= table_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - FOUND_W - SLOT_PORT_W){1'b0}}, found_ff, slot_ff};

endmodule

### test/lpht_response_check.sv
`timescale 1ns / 100ps

module lpht_response_check
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] lookup_key, [31:16] entry_value
   input  logic [KIND_W-1:0]     req_tuser,  // [1:0] kind
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] slot_index, [19:4] found_value, [23:20] zero
   input  logic [STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   output int                    fail_count,
   output int                    words_pending
);

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SLOT_PORT_W-1:0] slot;
      logic [FOUND_W-1:0]     found;
   } table_result_type;

   logic [KEY_PORT_W-1:0]   slot_key   [TABLE_SLOTS];
   logic [VALUE_PORT_W-1:0] slot_value [TABLE_SLOTS];
   logic                    slot_used  [TABLE_SLOTS];

   table_result_type expected_results [$];
   int               errors        = 0;
   int               pending_words = 0;

   assign fail_count    = errors;
   assign words_pending = pending_words;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
   endtask

   // Runs one operation on the shadow table and returns the response it should produce.
   task automatic apply_request(input logic [KIND_W-1:0] kind,
                                input logic [KEY_PORT_W-1:0] key,
                                input logic [VALUE_PORT_W-1:0] value,
                                output table_result_type res);
      int slot;
      int probe;
      res        = '0;
      res.status = STATUS_MISSING;
      slot       = int'(key) % TABLE_SLOTS;
      if (kind == KIND_INSERT) begin
         res.status = STATUS_FULL;
         for (probe = 0; probe < TABLE_SLOTS; probe++) begin
            if (!slot_used[slot]) begin
               slot_used[slot]  = 1'b1;
               slot_key[slot]   = key;
               slot_value[slot] = value;
               res.status       = STATUS_OK;
               res.slot         = SLOT_PORT_W'(slot);
               break;
            end
            slot = (slot + 1) % TABLE_SLOTS;
         end
      end else if (kind == KIND_SEARCH || kind == KIND_DELETE) begin
         for (probe = 0; probe < TABLE_SLOTS; probe++) begin
            if (!slot_used[slot]) break;
            if (slot_key[slot] == key) begin
               res.status = STATUS_OK;
               res.slot   = SLOT_PORT_W'(slot);
               res.found  = slot_value[slot];
               if (kind == KIND_DELETE) slot_used[slot] = 1'b0;
               break;
            end
            slot = (slot + 1) % TABLE_SLOTS;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      table_result_type got;
      table_result_type want;
      int i;
      if (reset) begin
         for (i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
         expected_results.delete();
         pending_words <= 0;
      end else begin
         // The response side goes first: a word leaving now belongs to an older request.
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.slot   = rsp_tdata[3:0];
            got.found  = rsp_tdata[19:4];
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response word with nothing outstanding (%h)", got));
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
               if (got.slot !== want.slot)
                  report_mismatch($sformatf("slot_index %0d, wanted %0d", got.slot, want.slot));
               if (got.found !== want.found)
                  report_mismatch($sformatf("found_value %h, wanted %h", got.found, want.found));
            end
            if (rsp_tdata[23:20] !== 4'd0)
               report_mismatch($sformatf("padding bits %h not zero", rsp_tdata[23:20]));
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[15:0], req_tdata[31:16], want);
            expected_results.push_back(want);
         end
         pending_words <= expected_results.size();
      end
   end

endmodule

### test/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   // The fourth kind code is not an operation; the block must answer it with key not found.
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   // Random part: segments of request words, each with its own idling and operation mix.
   localparam int SEGMENTS      = 31;
   localparam int SEGMENT_WORDS = 50;
   localparam int POOL_KEYS     = 12;

   // The drain wait leaves a margin over the longest request.
   localparam int DRAIN_CYCLES  = 24;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [15:0] lookup_key, [31:16] entry_value
   logic [KIND_W-1:0]     req_tuser  = '0;  // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [3:0] slot_index, [19:4] found_value, [23:20] zero
   logic [STATUS_W-1:0]   rsp_tuser;        // [1:0] status

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int fail_count;
   int words_pending;

   // Keys reused within a segment, so that inserts, searches and deletes meet each other.
   logic [KEY_PORT_W-1:0] key_pool [POOL_KEYS];

   linear_probe_hash_table #(
      .TABLE_SLOTS (16),
      .KEY_BITS    (16),
      .VALUE_BITS  (16)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The checker watches both channels, keeps its own copy of the table and compares
   // every response word with the one it predicted.
   lpht_response_check #(
      .TABLE_SLOTS (16)
   ) response_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Safety net: a hung handshake ends the run here. A correct run needs well under a
   // tenth of this time.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // The receiver stalls each cycle at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Presents one request word and returns at the rising edge that accepts it. Ready is
   // sampled at the falling edge, where it already holds the value that the next rising
   // edge will see, so the handshake is read without racing the block's own updates.
   // Valid stays high from one word to the next when no idle cycle falls between them.
   task automatic send_word(input logic [KIND_W-1:0] kind,
                            input logic [KEY_PORT_W-1:0] key,
                            input logic [VALUE_PORT_W-1:0] value);
      bit took;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, key};
      do begin
         @(negedge clock);
         took = (req_tready === 1'b1);
         @(posedge clock);
      end while (!took);
   endtask

   // Most keys come from the pool, whose keys share a few home slots and so build long
   // probe chains; the rest span the whole key range.
   function automatic logic [KEY_PORT_W-1:0] pick_key();
      if ($urandom_range(99) < 70) return key_pool[$urandom_range(POOL_KEYS - 1)];
      return KEY_PORT_W'($urandom);
   endfunction

   initial begin : stimulus
      int seg;
      int i;
      int roll;
      int insert_pct;
      logic [3:0] homes [3];
      logic [KIND_W-1:0] kind;

      // Reset is released first; the block then sweeps its RAM with ready low,
      // which the handshake in send_word simply waits out.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words, no idling. Extremes of key and value first.
      send_word(KIND_INSERT, 16'h0000, 16'h0000);
      send_word(KIND_INSERT, 16'hFFFF, 16'hFFFF);
      send_word(KIND_SEARCH, 16'hFFFF, 16'h0000);
      send_word(KIND_UNKNOWN, 16'hFFFF, 16'hFFFF);
      // Two more keys with home slot 0 chain behind key 0. Deleting the middle one leaves
      // no tombstone, so the last one can no longer be reached.
      send_word(KIND_INSERT, 16'h0010, 16'h1234);
      send_word(KIND_INSERT, 16'h0020, 16'hA5A5);
      send_word(KIND_DELETE, 16'h0010, 16'hFFFF);
      send_word(KIND_SEARCH, 16'h0020, 16'h0000);
      // Search and delete that stop at an empty slot.
      send_word(KIND_SEARCH, 16'h0030, 16'h0000);
      send_word(KIND_DELETE, 16'h0030, 16'h0000);
      // Fill the thirteen free slots with keys homed on the last slot, so probes wrap.
      for (i = 0; i < 13; i++)
         send_word(KIND_INSERT, {12'(i + 1), 4'hF}, VALUE_PORT_W'($urandom));
      // With every slot used, an insert finds the table full and a search for an
      // absent key runs one whole pass without meeting an empty slot.
      send_word(KIND_INSERT, 16'h5A5A, 16'h5A5A);
      send_word(KIND_SEARCH, 16'h7777, 16'h0000);
      // The filler in slot 1 mends the chain, so the orphaned key is found again.
      send_word(KIND_DELETE, 16'h0020, 16'h0000);

      // Random part. The phase of idling rotates per segment; the operation mix swings
      // between filling and draining so the table keeps passing through full and empty.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 72;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 72;
            end
            default: begin
               sender_idle_pct    = 29;
               receiver_stall_pct = 29;
            end
         endcase
         case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         for (i = 0; i < 3; i++) homes[i] = 4'($urandom);
         for (i = 0; i < POOL_KEYS; i++) key_pool[i] = {12'($urandom), homes[i % 3]};

         repeat (SEGMENT_WORDS) begin
            roll = $urandom_range(99);
            if (roll < 2)
               kind = KIND_UNKNOWN;
            else if (roll < insert_pct)
               kind = KIND_INSERT;
            else if ($urandom_range(1) == 0)
               kind = KIND_SEARCH;
            else
               kind = KIND_DELETE;
            send_word(kind, pick_key(), VALUE_PORT_W'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // Let the checker count the last word, wait for every response, then watch a few
      // more cycles for a stray word before giving the verdict.
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
